// ----- src/msvf_pkg.sv -----
// ----------------------------------------------------------------------------
// msvf_pkg
// Shared types and constants of the multi-sensor tilt fusion core: field
// widths, opcodes, register indexes, block control structs and reciprocals.
// ----------------------------------------------------------------------------
package msvf_pkg;

    localparam int NUM_SENSORS = 3;
    localparam int ANGLE_W     = 16;
    localparam int GAIN_W      = 16;
    localparam int MAG_W       = 15;
    localparam int TIMEOUT_W   = 16;
    localparam int LIMIT_W     = 8;
    localparam int VEL_W       = 20;
    localparam int SUM_W       = 22;
    localparam int MUL_A_W     = 22;
    localparam int MUL_B_W     = 24;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int SHAPE_PROD_W = MAG_W + GAIN_W;
    localparam int FRAC_BITS   = 12;
    localparam int TERM_W      = SHAPE_PROD_W - FRAC_BITS;
    localparam int RECIP_SHIFT = 23;
    localparam int ROUND_HALF  = 2048;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic [GAIN_W-1:0]         gain_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic signed [VEL_W-1:0]   vel_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [MUL_A_W-1:0]        mul_a_t;
    typedef logic [MUL_B_W-1:0]        mul_b_t;
    typedef logic [PROD_W-1:0]         prod_t;
    typedef logic [1:0]                sensor_id_t;
    typedef logic [1:0]                opcode_t;
    typedef logic [2:0]                reg_index_t;
    typedef logic [15:0]               reg_data_t;
    typedef logic [NUM_SENSORS-1:0]    mask_t;

    localparam opcode_t OP_SAMPLE = 2'd0;
    localparam opcode_t OP_TICK   = 2'd1;
    localparam opcode_t OP_STEP   = 2'd2;

    localparam reg_index_t REG_LINEAR_GAIN     = 3'd0;
    localparam reg_index_t REG_ANGULAR_GAIN    = 3'd1;
    localparam reg_index_t REG_PITCH_DEAD_ZONE = 3'd2;
    localparam reg_index_t REG_PITCH_CLAMP     = 3'd3;
    localparam reg_index_t REG_ROLL_DEAD_ZONE  = 3'd4;
    localparam reg_index_t REG_ROLL_CLAMP      = 3'd5;
    localparam reg_index_t REG_TIMEOUT_TICKS   = 3'd6;
    localparam reg_index_t REG_STUCK_LIMIT     = 3'd7;

    localparam sensor_id_t SENSOR_NO_ROLL = 2'd1;
    localparam sensor_id_t SENSOR_LAST    = 2'd2;

    localparam mul_b_t RECIP_BY_ONE   = 24'h800000;
    localparam mul_b_t RECIP_BY_TWO   = 24'h400000;
    localparam mul_b_t RECIP_BY_THREE = 24'h2AAAAB;

    typedef struct packed {
        logic       sample_we;
        sensor_id_t sample_id;
        logic       tick;
        logic       check_en;
        sensor_id_t sel;
    } bank_ctl_t;

    typedef struct packed {
        logic   active;
        logic   keep;
        angle_t roll;
        angle_t pitch;
    } bank_sts_t;

    function automatic mul_b_t div_recip(input logic [1:0] n);
        mul_b_t r;
        case (n)
            2'd1:    r = RECIP_BY_ONE;
            2'd2:    r = RECIP_BY_TWO;
            2'd3:    r = RECIP_BY_THREE;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/msvf_mul_unit.sv -----
// ----------------------------------------------------------------------------
// msvf_mul_unit
// Shared unsigned multiplier with a registered product, used for gain
// scaling of every sensor and for the reciprocal divides of the averages.
// ----------------------------------------------------------------------------
module msvf_mul_unit (
    input  logic            clk,
    input  logic            en,
    input  msvf_pkg::mul_a_t a,
    input  msvf_pkg::mul_b_t b,
    output msvf_pkg::prod_t  prod
);
    import msvf_pkg::*;

    prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

// ----- src/msvf_sensor_bank.sv -----
// ----------------------------------------------------------------------------
// msvf_sensor_bank
// Per-sensor state: current and previous angles, active flags, sample ages
// and unchanged counters, with the stale and stuck check of one sensor.
// ----------------------------------------------------------------------------
module msvf_sensor_bank #(
    parameter int AGE_BITS   = 16,
    parameter int STUCK_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  msvf_pkg::bank_ctl_t  ctl,
    input  msvf_pkg::angle_t     sample_roll,
    input  msvf_pkg::angle_t     sample_pitch,
    input  logic [15:0]          timeout_ticks,
    input  logic [7:0]           stuck_limit,
    output msvf_pkg::bank_sts_t  sts
);
    import msvf_pkg::*;

    localparam int AGE_CMP_W   = (AGE_BITS > TIMEOUT_W) ? AGE_BITS : TIMEOUT_W;
    localparam int STUCK_CMP_W = (STUCK_BITS > LIMIT_W) ? STUCK_BITS : LIMIT_W;

    logic                  active_reg [NUM_SENSORS];
    angle_t                roll_now_reg [NUM_SENSORS];
    angle_t                pitch_now_reg [NUM_SENSORS];
    angle_t                roll_before_reg [NUM_SENSORS];
    angle_t                pitch_before_reg [NUM_SENSORS];
    logic [STUCK_BITS-1:0] count_reg [NUM_SENSORS];
    logic [AGE_BITS-1:0]   age_reg [NUM_SENSORS];

    logic                  same;
    logic                  drop;
    logic [STUCK_BITS-1:0] count_next;

    always_comb
    begin
        same = (pitch_before_reg[ctl.sel] == pitch_now_reg[ctl.sel]) &&
               ((ctl.sel == SENSOR_NO_ROLL) ||
                (roll_before_reg[ctl.sel] == roll_now_reg[ctl.sel]));
        if (!same)
        begin
            count_next = '0;
        end
        else if (count_reg[ctl.sel] == {STUCK_BITS{1'b1}})
        begin
            count_next = count_reg[ctl.sel];
        end
        else
        begin
            count_next = count_reg[ctl.sel] + STUCK_BITS'(1);
        end
        drop = (AGE_CMP_W'(age_reg[ctl.sel]) > AGE_CMP_W'(timeout_ticks)) ||
               (STUCK_CMP_W'(count_next) > STUCK_CMP_W'(stuck_limit));
        sts.active = active_reg[ctl.sel];
        sts.keep   = active_reg[ctl.sel] && !drop;
        sts.roll   = roll_now_reg[ctl.sel];
        sts.pitch  = pitch_now_reg[ctl.sel];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                active_reg[i]       <= 1'b0;
                roll_now_reg[i]     <= '0;
                pitch_now_reg[i]    <= '0;
                roll_before_reg[i]  <= '0;
                pitch_before_reg[i] <= '0;
                count_reg[i]        <= '0;
                age_reg[i]          <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                if (ctl.sample_we && (ctl.sample_id == 2'(i)))
                begin
                    roll_now_reg[i]  <= sample_roll;
                    pitch_now_reg[i] <= sample_pitch;
                    active_reg[i]    <= 1'b1;
                    age_reg[i]       <= '0;
                end
                if (ctl.tick && (age_reg[i] != {AGE_BITS{1'b1}}))
                begin
                    age_reg[i] <= age_reg[i] + AGE_BITS'(1);
                end
                if (ctl.check_en && (ctl.sel == 2'(i)) && active_reg[i])
                begin
                    count_reg[i]        <= count_next;
                    active_reg[i]       <= !drop;
                    roll_before_reg[i]  <= roll_now_reg[i];
                    pitch_before_reg[i] <= pitch_now_reg[i];
                end
            end
        end
    end

endmodule

// ----- src/multi_sensor_teleop_velocity_fusion_core.sv -----
// ----------------------------------------------------------------------------
// multi_sensor_teleop_velocity_fusion_core
// Fuses tilt angles of three sensors into averaged linear and angular drive
// commands under a small sequencer around one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid/item_ready) carries opcode, sensor_id, roll and
//   pitch. A sample (opcode 0) or a tick (opcode 1) gives no result and leaves
//   the block idle; opcode 3 is dropped the same way.
//   A control step (opcode 2) walks the three sensors through the shared
//   multiplier, pitch then roll, one product per cycle, then divides both
//   sums by the active counts through the same multiplier with reciprocals.
//   Sensor steps are followed by drain, linear divide, angular divide and
//   finish, which loads the output register behind result_valid; item_ready
//   stays low from the step's acceptance until then, so the step holds the block.
//   The output register holds a result until result_ready; while it is full,
//   samples and ticks are still taken, and a following step waits in its
//   last cycle until the register frees.
//   Registers must be written via write_enable/reg_index/write_data only
//   while the block is idle; the block does not enforce this. Reset clears
//   all sensor state, loads the register defaults and leaves the block ready.
// ----------------------------------------------------------------------------
module multi_sensor_teleop_velocity_fusion_core #(
    parameter int AGE_BITS   = 16,
    parameter int STUCK_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  msvf_pkg::opcode_t      opcode,
    input  msvf_pkg::sensor_id_t   sensor_id,
    input  msvf_pkg::angle_t       roll,
    input  msvf_pkg::angle_t       pitch,
    output logic                   result_valid,
    input  logic                   result_ready,
    output msvf_pkg::vel_t         linear_velocity,
    output msvf_pkg::vel_t         angular_velocity,
    output msvf_pkg::mask_t        active_mask,
    input  logic                   write_enable,
    input  msvf_pkg::reg_index_t   reg_index,
    input  msvf_pkg::reg_data_t    write_data
);
    import msvf_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SHAPE   = 3'd1;
    localparam logic [2:0] ST_DRAIN   = 3'd2;
    localparam logic [2:0] ST_DIV_LIN = 3'd3;
    localparam logic [2:0] ST_DIV_ANG = 3'd4;
    localparam logic [2:0] ST_FINISH  = 3'd5;

    localparam logic [2:0] LAST_STEP = 3'd5;

    // configuration
    gain_t       linear_gain_reg;
    gain_t       angular_gain_reg;
    mag_t        pitch_dead_zone_reg;
    mag_t        pitch_clamp_reg;
    mag_t        roll_dead_zone_reg;
    mag_t        roll_clamp_reg;
    logic [15:0] timeout_ticks_reg;
    logic [7:0]  stuck_limit_reg;

    // sequencer and datapath
    logic [2:0] state_reg, state_next;
    logic [2:0] step_reg, step_next;
    sum_t       lin_sum_reg, lin_sum_next;
    sum_t       ang_sum_reg, ang_sum_next;
    logic [1:0] lin_n_reg, lin_n_next;
    logic [1:0] ang_n_reg, ang_n_next;
    mask_t      mask_acc_reg, mask_acc_next;
    logic       tag_add_reg, tag_add_next;
    logic       tag_roll_reg, tag_roll_next;
    logic       tag_neg_reg, tag_neg_next;
    vel_t       lin_q_reg, lin_q_next;
    logic       out_valid_reg, out_valid_next;
    vel_t       lin_out_reg, lin_out_next;
    vel_t       ang_out_reg, ang_out_next;
    mask_t      mask_out_reg, mask_out_next;

    logic       accept;
    bank_ctl_t  bank_ctl;
    bank_sts_t  bank_sts;
    sensor_id_t sel;
    logic       is_roll;
    angle_t     shape_val;
    logic [ANGLE_W:0] shape_ext;
    logic [ANGLE_W:0] raw_mag;
    mag_t       dead_sel;
    mag_t       clamp_sel;
    gain_t      gain_sel;
    mag_t       shaped_mag;
    logic       mul_en;
    mul_a_t     mul_a;
    mul_b_t     mul_b;
    prod_t      prod;
    logic [SHAPE_PROD_W-1:0] rounded;
    sum_t       term_mag;
    sum_t       term;
    sum_t       lin_abs;
    sum_t       ang_abs;
    vel_t       quot;
    vel_t       quot_neg;
    logic       load_out;

    assign accept     = item_valid && item_ready;
    assign item_ready = (state_reg == ST_IDLE);
    assign sel        = step_reg[2:1];
    assign is_roll    = step_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_gain_reg     <= 16'd8192;
            angular_gain_reg    <= 16'd4096;
            pitch_dead_zone_reg <= 15'd410;
            pitch_clamp_reg     <= 15'd5325;
            roll_dead_zone_reg  <= 15'd819;
            roll_clamp_reg      <= 15'd6144;
            timeout_ticks_reg   <= 16'd1000;
            stuck_limit_reg     <= 8'd4;
        end
        else if (write_enable)
        begin
            case (reg_index)
                REG_LINEAR_GAIN:     linear_gain_reg     <= write_data;
                REG_ANGULAR_GAIN:    angular_gain_reg    <= write_data;
                REG_PITCH_DEAD_ZONE: pitch_dead_zone_reg <= write_data[MAG_W-1:0];
                REG_PITCH_CLAMP:     pitch_clamp_reg     <= write_data[MAG_W-1:0];
                REG_ROLL_DEAD_ZONE:  roll_dead_zone_reg  <= write_data[MAG_W-1:0];
                REG_ROLL_CLAMP:      roll_clamp_reg      <= write_data[MAG_W-1:0];
                REG_TIMEOUT_TICKS:   timeout_ticks_reg   <= write_data;
                REG_STUCK_LIMIT:     stuck_limit_reg     <= write_data[LIMIT_W-1:0];
                default:             stuck_limit_reg     <= stuck_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        bank_ctl.sample_we = accept && (opcode == OP_SAMPLE);
        bank_ctl.sample_id = (sensor_id > SENSOR_LAST) ? SENSOR_LAST : sensor_id;
        bank_ctl.tick      = accept && (opcode == OP_TICK);
        bank_ctl.check_en  = (state_reg == ST_SHAPE) && !is_roll;
        bank_ctl.sel       = sel;
    end

    msvf_sensor_bank #(
        .AGE_BITS   (AGE_BITS),
        .STUCK_BITS (STUCK_BITS)
    ) u_bank (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (bank_ctl),
        .sample_roll   (roll),
        .sample_pitch  (pitch),
        .timeout_ticks (timeout_ticks_reg),
        .stuck_limit   (stuck_limit_reg),
        .sts           (bank_sts)
    );

    // dead zone and clamp of the selected angle
    always_comb
    begin
        shape_val = is_roll ? bank_sts.roll : bank_sts.pitch;
        dead_sel  = is_roll ? roll_dead_zone_reg : pitch_dead_zone_reg;
        clamp_sel = is_roll ? roll_clamp_reg : pitch_clamp_reg;
        gain_sel  = is_roll ? angular_gain_reg : linear_gain_reg;
        shape_ext = {shape_val[ANGLE_W-1], shape_val};
        raw_mag   = shape_val[ANGLE_W-1] ? (~shape_ext + (ANGLE_W+1)'(1)) : shape_ext;
        if (raw_mag < (ANGLE_W+1)'(dead_sel))
        begin
            shaped_mag = '0;
        end
        else if (raw_mag > (ANGLE_W+1)'(clamp_sel))
        begin
            shaped_mag = clamp_sel;
        end
        else
        begin
            shaped_mag = raw_mag[MAG_W-1:0];
        end
    end

    always_comb
    begin
        lin_abs = lin_sum_reg[SUM_W-1] ? (~lin_sum_reg + SUM_W'(1)) : lin_sum_reg;
        ang_abs = ang_sum_reg[SUM_W-1] ? (~ang_sum_reg + SUM_W'(1)) : ang_sum_reg;
        mul_en  = (state_reg == ST_SHAPE) || (state_reg == ST_DIV_LIN) ||
                  (state_reg == ST_DIV_ANG);
        case (state_reg)
            ST_DIV_LIN:
            begin
                mul_a = MUL_A_W'(lin_abs);
                mul_b = div_recip(lin_n_reg);
            end
            ST_DIV_ANG:
            begin
                mul_a = MUL_A_W'(ang_abs);
                mul_b = div_recip(ang_n_reg);
            end
            default:
            begin
                mul_a = MUL_A_W'(shaped_mag);
                mul_b = MUL_B_W'(gain_sel);
            end
        endcase
    end

    msvf_mul_unit u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_comb
    begin
        rounded  = prod[SHAPE_PROD_W-1:0] + SHAPE_PROD_W'(ROUND_HALF);
        term_mag = SUM_W'(rounded[SHAPE_PROD_W-1:FRAC_BITS]);
        term     = tag_neg_reg ? (~term_mag + SUM_W'(1)) : term_mag;
        quot     = prod[RECIP_SHIFT +: VEL_W];
        quot_neg = ~quot + VEL_W'(1);
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        lin_sum_next   = lin_sum_reg;
        ang_sum_next   = ang_sum_reg;
        lin_n_next     = lin_n_reg;
        ang_n_next     = ang_n_reg;
        mask_acc_next  = mask_acc_reg;
        tag_add_next   = 1'b0;
        tag_roll_next  = tag_roll_reg;
        tag_neg_next   = tag_neg_reg;
        lin_q_next     = lin_q_reg;
        lin_out_next   = lin_out_reg;
        ang_out_next   = ang_out_reg;
        mask_out_next  = mask_out_reg;
        load_out       = 1'b0;

        // fold in the product issued last cycle
        if (tag_add_reg)
        begin
            if (tag_roll_reg)
            begin
                ang_sum_next = ang_sum_reg + term;
            end
            else
            begin
                lin_sum_next = lin_sum_reg + term;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (opcode == OP_STEP))
                begin
                    state_next    = ST_SHAPE;
                    step_next     = '0;
                    lin_sum_next  = '0;
                    ang_sum_next  = '0;
                    lin_n_next    = '0;
                    ang_n_next    = '0;
                    mask_acc_next = '0;
                end
            end
            ST_SHAPE:
            begin
                tag_roll_next = is_roll;
                tag_neg_next  = shape_val[ANGLE_W-1];
                if (is_roll)
                begin
                    tag_add_next = bank_sts.active && (sel != SENSOR_NO_ROLL);
                end
                else
                begin
                    tag_add_next = bank_sts.keep;
                    if (bank_sts.keep)
                    begin
                        lin_n_next         = lin_n_reg + 2'd1;
                        mask_acc_next[sel] = 1'b1;
                        if (sel != SENSOR_NO_ROLL)
                        begin
                            ang_n_next = ang_n_reg + 2'd1;
                        end
                    end
                end
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DIV_LIN;
            end
            ST_DIV_LIN:
            begin
                state_next = ST_DIV_ANG;
            end
            ST_DIV_ANG:
            begin
                lin_q_next = lin_sum_reg[SUM_W-1] ? quot_neg : quot;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    load_out      = 1'b1;
                    lin_out_next  = lin_q_reg;
                    ang_out_next  = ang_sum_reg[SUM_W-1] ? quot_neg : quot;
                    mask_out_next = mask_acc_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            lin_n_reg     <= '0;
            ang_n_reg     <= '0;
            mask_acc_reg  <= '0;
            tag_add_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            lin_n_reg     <= lin_n_next;
            ang_n_reg     <= ang_n_next;
            mask_acc_reg  <= mask_acc_next;
            tag_add_reg   <= tag_add_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lin_sum_reg  <= lin_sum_next;
        ang_sum_reg  <= ang_sum_next;
        tag_roll_reg <= tag_roll_next;
        tag_neg_reg  <= tag_neg_next;
        lin_q_reg    <= lin_q_next;
        lin_out_reg  <= lin_out_next;
        ang_out_reg  <= ang_out_next;
        mask_out_reg <= mask_out_next;
    end

    assign result_valid     = out_valid_reg;
    assign linear_velocity  = lin_out_reg;
    assign angular_velocity = ang_out_reg;
    assign active_mask      = mask_out_reg;

    a_ang_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ang_n_reg <= lin_n_reg)
        else $error("angular count exceeds linear count");

    a_mask_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> ($countones(mask_acc_reg) == lin_n_reg))
        else $error("active mask disagrees with active count");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the final sequencer state");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHAPE) |-> (step_reg <= LAST_STEP))
        else $error("sensor step counter out of range");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-sensor tilt fusion core. A queue-fed
// driver sends samples, ticks, control steps and ignored opcodes, while an
// in-bench predictor of the fusion arithmetic and of the per-sensor state
// builds the expected drive commands. A monitor compares each command with
// the oldest expectation. Register settings change between phases while the
// core is idle; both sides stall at random, with one phase free of stalls.
// ----------------------------------------------------------------------------
module testbench;
    import msvf_pkg::*;

    localparam logic [15:0] AGE_FULL   = 16'hFFFF;
    localparam logic [7:0]  COUNT_FULL = 8'hFF;
    localparam int          SETTLE_CYCLES = 24;
    localparam opcode_t     OP_UNUSED  = 2'd3;

    typedef struct packed {
        opcode_t    op;
        sensor_id_t id;
        angle_t     roll;
        angle_t     pitch;
    } tilt_item_t;

    typedef struct packed {
        vel_t  lin;
        vel_t  ang;
        mask_t mask;
    } drive_cmd_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    opcode_t    opcode = OP_SAMPLE;
    sensor_id_t sensor_id = '0;
    angle_t     roll = '0;
    angle_t     pitch = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    vel_t       linear_velocity;
    vel_t       angular_velocity;
    mask_t      active_mask;
    logic       write_enable = 1'b0;
    reg_index_t reg_index = REG_LINEAR_GAIN;
    reg_data_t  write_data = '0;

    multi_sensor_teleop_velocity_fusion_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .opcode           (opcode),
        .sensor_id        (sensor_id),
        .roll             (roll),
        .pitch            (pitch),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .linear_velocity  (linear_velocity),
        .angular_velocity (angular_velocity),
        .active_mask      (active_mask),
        .write_enable     (write_enable),
        .reg_index        (reg_index),
        .write_data       (write_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    tilt_item_t queued_items[$];
    drive_cmd_t expected_cmds[$];
    tilt_item_t on_bus;
    drive_cmd_t oldest_cmd;
    bit         steady = 1'b0;

    gain_t       lin_gain_r;
    gain_t       ang_gain_r;
    mag_t        pitch_dz_r;
    mag_t        pitch_cl_r;
    mag_t        roll_dz_r;
    mag_t        roll_cl_r;
    logic [15:0] timeout_r;
    logic [7:0]  stuck_lim_r;

    logic        live       [NUM_SENSORS];
    angle_t      cur_roll   [NUM_SENSORS];
    angle_t      cur_pitch  [NUM_SENSORS];
    angle_t      last_roll  [NUM_SENSORS];
    angle_t      last_pitch [NUM_SENSORS];
    logic [7:0]  same_count [NUM_SENSORS];
    logic [15:0] age_ticks  [NUM_SENSORS];

    angle_t      gen_roll  [NUM_SENSORS];
    angle_t      gen_pitch [NUM_SENSORS];

    int n_steps = 0;
    int n_samples = 0;
    int n_ticks = 0;
    int n_ignored = 0;
    int n_checked = 0;
    int n_settings = 0;
    int fault_count = 0;

    function automatic int shape_angle(input angle_t a, input mag_t dead, input mag_t clamp,
                                       input gain_t gain);
        int     ai;
        int     mag;
        longint r;
        ai = a;
        mag = (ai < 0) ? -ai : ai;
        if (mag < int'(dead))
            return 0;
        if (mag > int'(clamp))
            mag = int'(clamp);
        r = (longint'(mag) * longint'(gain) + 2048) >>> 12;
        return (ai < 0) ? -int'(r) : int'(r);
    endfunction

    task automatic fuse_transaction(input tilt_item_t it);
        sensor_id_t id;
        int         lin_sum;
        int         ang_sum;
        int         lin_n;
        int         ang_n;
        int         lv;
        int         av;
        logic       same;
        drive_cmd_t cmd;
        id = (it.id > SENSOR_LAST) ? SENSOR_LAST : it.id;
        case (it.op)
            OP_SAMPLE:
            begin
                cur_roll[id] = it.roll;
                cur_pitch[id] = it.pitch;
                live[id] = 1'b1;
                age_ticks[id] = '0;
                n_samples++;
            end
            OP_TICK:
            begin
                for (int s = 0; s < NUM_SENSORS; s++)
                    if (age_ticks[s] != AGE_FULL)
                        age_ticks[s] = age_ticks[s] + 16'd1;
                n_ticks++;
            end
            OP_STEP:
            begin
                lin_sum = 0;
                ang_sum = 0;
                lin_n = 0;
                ang_n = 0;
                cmd = '0;
                for (int s = 0; s < NUM_SENSORS; s++)
                begin
                    if (live[s])
                    begin
                        av = 0;
                        lv = shape_angle(cur_pitch[s], pitch_dz_r, pitch_cl_r, lin_gain_r);
                        if (s != SENSOR_NO_ROLL)
                            av = shape_angle(cur_roll[s], roll_dz_r, roll_cl_r, ang_gain_r);
                        same = (last_pitch[s] == cur_pitch[s]) &&
                               (s == SENSOR_NO_ROLL || last_roll[s] == cur_roll[s]);
                        if (!same)
                            same_count[s] = '0;
                        else if (same_count[s] != COUNT_FULL)
                            same_count[s] = same_count[s] + 8'd1;
                        if (age_ticks[s] > timeout_r || same_count[s] > stuck_lim_r)
                            live[s] = 1'b0;
                        last_roll[s] = cur_roll[s];
                        last_pitch[s] = cur_pitch[s];
                        if (live[s])
                        begin
                            cmd.mask[s] = 1'b1;
                            lin_sum += lv;
                            lin_n++;
                            if (s != SENSOR_NO_ROLL)
                            begin
                                ang_sum += av;
                                ang_n++;
                            end
                        end
                    end
                end
                if (lin_n > 0)
                    cmd.lin = vel_t'(lin_sum / lin_n);
                if (ang_n > 0)
                    cmd.ang = vel_t'(ang_sum / ang_n);
                expected_cmds.push_back(cmd);
                n_steps++;
            end
            default:
                n_ignored++;
        endcase
    endtask

    task automatic report_fault(input string what);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch: %s", what);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                fuse_transaction(on_bus);
            if (!item_valid || item_ready)
            begin
                if (queued_items.size() != 0 && (steady || $urandom_range(99) >= 16))
                begin
                    on_bus = queued_items.pop_front();
                    item_valid <= 1'b1;
                    opcode <= on_bus.op;
                    sensor_id <= on_bus.id;
                    roll <= on_bus.roll;
                    pitch <= on_bus.pitch;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (expected_cmds.size() == 0)
                    report_fault($sformatf("unexpected command lin=%0d ang=%0d mask=%b",
                                           linear_velocity, angular_velocity, active_mask));
                else
                begin
                    oldest_cmd = expected_cmds.pop_front();
                    n_checked++;
                    if (linear_velocity !== oldest_cmd.lin ||
                        angular_velocity !== oldest_cmd.ang ||
                        active_mask !== oldest_cmd.mask)
                        report_fault($sformatf(
                            "command %0d expected lin=%0d ang=%0d mask=%b got lin=%0d ang=%0d mask=%b",
                            n_checked, oldest_cmd.lin, oldest_cmd.ang, oldest_cmd.mask,
                            linear_velocity, angular_velocity, active_mask));
                end
            end
            result_ready <= steady || ($urandom_range(99) >= 16);
        end
    end

    task automatic queue_item(input opcode_t op, input sensor_id_t id, input int r, input int p);
        tilt_item_t it;
        it.op = op;
        it.id = id;
        it.roll = angle_t'(r);
        it.pitch = angle_t'(p);
        queued_items.push_back(it);
    endtask

    task automatic write_reg(input reg_index_t idx, input int value);
        reg_data_t data;
        data = reg_data_t'(value);
        @(posedge clk);
        write_enable <= 1'b1;
        reg_index <= idx;
        write_data <= data;
        case (idx)
            REG_LINEAR_GAIN:     lin_gain_r = gain_t'(data);
            REG_ANGULAR_GAIN:    ang_gain_r = gain_t'(data);
            REG_PITCH_DEAD_ZONE: pitch_dz_r = mag_t'(data);
            REG_PITCH_CLAMP:     pitch_cl_r = mag_t'(data);
            REG_ROLL_DEAD_ZONE:  roll_dz_r = mag_t'(data);
            REG_ROLL_CLAMP:      roll_cl_r = mag_t'(data);
            REG_TIMEOUT_TICKS:   timeout_r = data;
            default:             stuck_lim_r = data[7:0];
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        write_enable <= 1'b0;
        n_settings++;
        @(negedge clk);
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (queued_items.size() != 0 || item_valid || expected_cmds.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic int pick_value(input int lo, input int hi, input int typical_hi);
        case ($urandom_range(7))
            0:       return lo;
            1:       return hi;
            2, 3, 4: return int'($urandom_range(typical_hi, lo));
            default: return int'($urandom_range(hi, lo));
        endcase
    endfunction

    task automatic randomize_config();
        write_reg(REG_LINEAR_GAIN, pick_value(0, 65535, 16384));
        write_reg(REG_ANGULAR_GAIN, pick_value(0, 65535, 16384));
        write_reg(REG_PITCH_DEAD_ZONE, pick_value(0, 32767, 2000) | ($urandom_range(1) << 15));
        write_reg(REG_PITCH_CLAMP, pick_value(0, 32767, 8000) | ($urandom_range(1) << 15));
        write_reg(REG_ROLL_DEAD_ZONE, pick_value(0, 32767, 2000) | ($urandom_range(1) << 15));
        write_reg(REG_ROLL_CLAMP, pick_value(0, 32767, 8000) | ($urandom_range(1) << 15));
        write_reg(REG_TIMEOUT_TICKS, pick_value(1, 65535, 40));
        write_reg(REG_STUCK_LIMIT, pick_value(0, 254, 8) | ($urandom_range(255) << 8));
        end_writes();
    endtask

    function automatic angle_t angle_near(input mag_t dz, input mag_t cl);
        int m;
        case ($urandom_range(9))
            0:       m = 32767;
            1:       m = 32768;
            2:       m = 0;
            3, 4:    m = int'(dz) + int'($urandom_range(2)) - 1;
            5, 6:    m = int'(cl) + int'($urandom_range(2)) - 1;
            default: return angle_t'($urandom);
        endcase
        if (m < 0)
            m = 0;
        return $urandom_range(1) ? angle_t'(-m) : angle_t'(m);
    endfunction

    task automatic queue_random_items(input int count);
        sensor_id_t id;
        int         slot;
        int         kind;
        int         burst;
        for (int k = 0; k < count; k++)
        begin
            kind = $urandom_range(99);
            if (kind < 38)
            begin
                id = sensor_id_t'($urandom_range(3));
                slot = (id > SENSOR_LAST) ? SENSOR_LAST : id;
                if ($urandom_range(3) != 0)
                begin
                    gen_roll[slot] = angle_near(roll_dz_r, roll_cl_r);
                    gen_pitch[slot] = angle_near(pitch_dz_r, pitch_cl_r);
                end
                queue_item(OP_SAMPLE, id, gen_roll[slot], gen_pitch[slot]);
            end
            else if (kind < 55)
            begin
                burst = ($urandom_range(7) == 0) ? $urandom_range(12, 2) : 1;
                repeat (burst) queue_item(OP_TICK, sensor_id_t'($urandom_range(3)),
                                          $urandom, $urandom);
            end
            else if (kind < 95)
                queue_item(OP_STEP, sensor_id_t'($urandom_range(3)), $urandom, $urandom);
            else
                queue_item(OP_UNUSED, sensor_id_t'($urandom_range(3)),
                           $urandom, $urandom);
        end
    endtask

    initial
    begin
        lin_gain_r = 16'd8192;
        ang_gain_r = 16'd4096;
        pitch_dz_r = 15'd410;
        pitch_cl_r = 15'd5325;
        roll_dz_r = 15'd819;
        roll_cl_r = 15'd6144;
        timeout_r = 16'd1000;
        stuck_lim_r = 8'd4;
        for (int s = 0; s < NUM_SENSORS; s++)
        begin
            live[s] = 1'b0;
            cur_roll[s] = '0;
            cur_pitch[s] = '0;
            last_roll[s] = '0;
            last_pitch[s] = '0;
            same_count[s] = '0;
            age_ticks[s] = '0;
            gen_roll[s] = '0;
            gen_pitch[s] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: empty fusion, field extremes, dead zone and clamp edges
        queue_item(OP_STEP, 2'd0, 0, 0);
        queue_item(OP_SAMPLE, 2'd0, 32767, -32768);
        queue_item(OP_SAMPLE, 2'd1, -1, 32767);
        queue_item(OP_SAMPLE, 2'd3, -32768, 0);
        queue_item(OP_STEP, 2'd0, 0, 0);
        queue_item(OP_UNUSED, 2'd1, 1234, -1234);
        queue_item(OP_TICK, 2'd0, 0, 0);
        queue_item(OP_SAMPLE, 2'd0, -818, 409);
        queue_item(OP_SAMPLE, 2'd1, 5, 410);
        queue_item(OP_SAMPLE, 2'd2, 819, -5326);
        queue_item(OP_STEP, 2'd2, 0, 0);
        queue_item(OP_SAMPLE, 2'd0, 6144, -5325);
        queue_item(OP_STEP, 2'd1, 0, 0);
        repeat (6) queue_item(OP_STEP, 2'd3, -1, -1);
        // roll change alone does not count for the roll-less sensor
        queue_item(OP_SAMPLE, 2'd1, 100, 410);
        queue_item(OP_STEP, 2'd0, 0, 0);
        settle();

        write_reg(REG_LINEAR_GAIN, 65535);
        write_reg(REG_ANGULAR_GAIN, 0);
        write_reg(REG_PITCH_DEAD_ZONE, 0);
        write_reg(REG_PITCH_CLAMP, 32767);
        write_reg(REG_ROLL_DEAD_ZONE, 32767);
        write_reg(REG_ROLL_CLAMP, 0);
        write_reg(REG_TIMEOUT_TICKS, 1);
        write_reg(REG_STUCK_LIMIT, 0);
        end_writes();
        queue_item(OP_SAMPLE, 2'd0, 32767, -32768);
        queue_item(OP_SAMPLE, 2'd1, 0, -32768);
        queue_item(OP_SAMPLE, 2'd2, -32768, 32767);
        queue_item(OP_STEP, 2'd0, 0, 0);
        queue_item(OP_TICK, 2'd0, 0, 0);
        queue_item(OP_TICK, 2'd0, 0, 0);
        queue_item(OP_STEP, 2'd0, 0, 0);
        settle();

        for (int p = 0; p < 5; p++)
        begin
            randomize_config();
            steady = (p == 2);
            queue_random_items(300);
            settle();
        end
        steady = 1'b0;

        if (expected_cmds.size() != 0)
            report_fault($sformatf("%0d commands never arrived", expected_cmds.size()));
        $display("covered %0d control steps, %0d samples, %0d ticks, %0d ignored items",
                 n_steps, n_samples, n_ticks, n_ignored);
        $display("over %0d register settings; %0d commands checked, %0d mismatches",
                 n_settings, n_checked, fault_count);
        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d commands outstanding", expected_cmds.size());
        $display("status: fail");
        $finish;
    end

endmodule
